// ===== src/context_rank_nibble_encoder_core_macros.svh =====
// assertion macros shared by the encoder modules
`ifndef CONTEXT_RANK_NIBBLE_ENCODER_CORE_MACROS_SVH
`define CONTEXT_RANK_NIBBLE_ENCODER_CORE_MACROS_SVH

// checked on every clock edge outside reset
`define CRNE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked on every clock edge, reset included
`define CRNE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== src/crne_pkg.sv =====
// shared types, code table and constants of the context rank nibble encoder
package crne_pkg;

  localparam int Q_DEPTH   = 4;
  localparam int OUT_DEPTH = 4;

  // one context: code state plus the rank permutation and its inverse
  typedef struct packed {
    logic [1:0]        code_state;
    logic [15:0][3:0]  s2r;
    logic [15:0][3:0]  r2s;
  } row_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HI_UPD,
    ST_LO_RD,
    ST_LO_UPD
  } back_state_t;

  // entry: [15:12] next code state, [11:8] code length, [7:0] code bits
  localparam logic [15:0] CODE_TAB [4][16] = '{
    '{16'h0100, 16'h0202, 16'h1306, 16'h140E, 16'h2778, 16'h2779, 16'h277A, 16'h277B,
      16'h38F8, 16'h38F9, 16'h38FA, 16'h38FB, 16'h38FC, 16'h38FD, 16'h38FE, 16'h38FF},
    '{16'h0200, 16'h0201, 16'h1304, 16'h1305, 16'h240C, 16'h240D, 16'h251C, 16'h251D,
      16'h363C, 16'h363D, 16'h38F8, 16'h38F9, 16'h38FA, 16'h38FB, 16'h38FC, 16'h38FD},
    '{16'h1300, 16'h1301, 16'h1302, 16'h1303, 16'h2408, 16'h2409, 16'h240A, 16'h240B,
      16'h3518, 16'h3519, 16'h351A, 16'h351B, 16'h351C, 16'h351D, 16'h351E, 16'h351F},
    '{16'h2400, 16'h2401, 16'h2402, 16'h2403, 16'h2404, 16'h2405, 16'h2406, 16'h2407,
      16'h3408, 16'h3409, 16'h340A, 16'h340B, 16'h340C, 16'h340D, 16'h340E, 16'h340F}
  };

  localparam logic [1:0] CODE_STATE_RESET = 2'd3;

  function automatic row_t row_reset();
    row_t r;
    r.code_state = CODE_STATE_RESET;
    for (int i = 0; i < 16; i++) begin
      r.s2r[i] = 4'(i);
      r.r2s[i] = 4'(i);
    end
    return r;
  endfunction

endpackage

// ===== src/context_rank_nibble_encoder_core.sv =====
// top level of the context rank nibble encoder
//
//  channel  | ports                          | direction | beat
//  ---------+--------------------------------+-----------+------------------------------
//  input    | in_valid in_stall in_byte_in   | in        | one data byte
//  result   | out_valid out_stall out_byte   | out       | one packed code byte, out_last
//           | out_last                       |           | on the final beat of a byte
//
//  bytes: the back finishes a byte before it takes the next, with two read-modify-write
//    passes over the context row memory (registered read, then update and write) for
//    the high and low nibble; the front register and queue lie ahead of the sequencer
//  reset: synchronous rst_n; afterwards a clear pass over all NUM_CONTEXTS rows writes the
//    identity permutation and code state 3 into every context, in_stall high meanwhile
//  stalls: a 4-entry queue parts front and back, a 4-entry output queue parts the back
//    from out_stall; the back starts a byte only with two free output slots
module context_rank_nibble_encoder_core #(
  parameter int NUM_CONTEXTS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  localparam int CW    = $clog2(NUM_CONTEXTS);
  localparam int ITEMW = 8 + 2 * CW;
  localparam int QCW   = $clog2(crne_pkg::Q_DEPTH + 1);
  localparam int OCW   = $clog2(crne_pkg::OUT_DEPTH + 1);
  localparam int OW    = $bits(crne_pkg::out_item_t);

  // front to queue
  logic                   q_push;
  logic [ITEMW-1:0]       q_push_data;
  // queue to back
  logic                   q_pop;
  logic [ITEMW-1:0]       q_pop_data;
  crne_pkg::fifo_status_t q_stat;
  logic [QCW-1:0]         q_count;
  // back to output queue
  logic                   clearing;
  logic                   o_push;
  crne_pkg::out_item_t    o_push_item;
  logic [OW-1:0]          o_pop_data;
  crne_pkg::fifo_status_t o_stat;
  logic [OCW-1:0]         o_count;
  logic                   o_pop;
  crne_pkg::out_item_t    o_head;

  // byte intake and context selection
  crne_front #(
    .NUM_CONTEXTS (NUM_CONTEXTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte_in (in_byte_in),
    .clearing   (clearing),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_data     (q_push_data)
  );

  // classified bytes waiting for the back end
  crne_fifo #(
    .WIDTH (ITEMW),
    .DEPTH (crne_pkg::Q_DEPTH)
  ) u_item_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .stat      (q_stat),
    .count     (q_count)
  );

  // per-nibble model update and code packing
  crne_back #(
    .NUM_CONTEXTS (NUM_CONTEXTS),
    .OUT_DEPTH    (crne_pkg::OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_count (o_count),
    .out_push  (o_push),
    .out_data  (o_push_item)
  );

  // result beats waiting for the consumer
  crne_fifo #(
    .WIDTH (OW),
    .DEPTH (crne_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (o_push),
    .push_data (o_push_item),
    .pop       (o_pop),
    .pop_data  (o_pop_data),
    .stat      (o_stat),
    .count     (o_count)
  );

  // queue head is the result register; it holds while stalled
  assign o_head    = crne_pkg::out_item_t'(o_pop_data);
  assign out_valid = !o_stat.empty;
  assign o_pop     = out_valid && !out_stall && (q_count <= QCW'(crne_pkg::Q_DEPTH));
  assign out_byte  = o_head.out_byte;
  assign out_last  = o_head.last;

endmodule

// ===== src/crne_fifo.sv =====
// small first-in first-out queue built from registers
`include "context_rank_nibble_encoder_core_macros.svh"

module crne_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      pop_data,
  output crne_pkg::fifo_status_t stat,
  output logic [CNTW-1:0]       count
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTRW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNTW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign count      = cnt_r;

  `CRNE_ASSERT(a_no_overflow, push |-> !stat.full || pop, "push into full queue")
  `CRNE_ASSERT_ALWAYS(a_no_underflow, pop |-> !stat.empty, "pop from empty queue")
  `CRNE_ASSERT(a_count_up, push && !pop |=> cnt_r == $past(cnt_r) + 1'b1, "count lost a push")

endmodule

// ===== src/crne_front.sv =====
// front end: takes input beats and works out the two context indexes per byte
module crne_front #(
  parameter int NUM_CONTEXTS = 256,
  localparam int CW    = $clog2(NUM_CONTEXTS),
  localparam int ITEMW = 8 + 2 * CW
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_byte_in,
  input  logic                   clearing,
  input  crne_pkg::fifo_status_t q_stat,
  output logic                   q_push,
  output logic [ITEMW-1:0]       q_data
);

  // context number of every possible nibble pair, reduced modulo the context count
  function automatic logic [255:0][CW-1:0] build_ctx_mod();
    logic [255:0][CW-1:0] t;
    for (int i = 0; i < 256; i++) begin
      t[i] = CW'(i % NUM_CONTEXTS);
    end
    return t;
  endfunction

  localparam logic [255:0][CW-1:0] CTX_MOD = build_ctx_mod();

  logic             accept;
  logic             fr_valid_r, fr_valid_nxt;
  logic [ITEMW-1:0] fr_data_r, fr_data_nxt;
  logic [7:0]       prev_byte_r, prev_byte_nxt;
  logic [7:0]       lo_pair;

  assign in_stall = clearing || (fr_valid_r && q_stat.full);
  assign accept   = in_valid && !in_stall;
  assign q_push   = fr_valid_r && !q_stat.full;
  assign q_data   = fr_data_r;

  // low nibble is coded after the high nibble of the same byte
  assign lo_pair = {prev_byte_r[3:0], in_byte_in[7:4]};

  always_comb begin
    fr_valid_nxt  = fr_valid_r && !q_push;
    fr_data_nxt   = fr_data_r;
    prev_byte_nxt = prev_byte_r;
    if (accept) begin
      fr_valid_nxt  = 1'b1;
      fr_data_nxt   = {in_byte_in, CTX_MOD[prev_byte_r], CTX_MOD[lo_pair]};
      prev_byte_nxt = in_byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r  <= 1'b0;
      prev_byte_r <= 8'h00;
    end else begin
      fr_valid_r  <= fr_valid_nxt;
      prev_byte_r <= prev_byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fr_data_r <= fr_data_nxt;
  end

endmodule

// ===== src/crne_back.sv =====
// back end: context memory read-modify-write, rank coding and bit packing
`include "context_rank_nibble_encoder_core_macros.svh"

module crne_back #(
  parameter int NUM_CONTEXTS = 256,
  parameter int OUT_DEPTH    = 4,
  localparam int CW    = $clog2(NUM_CONTEXTS),
  localparam int ITEMW = 8 + 2 * CW,
  localparam int OCW   = $clog2(OUT_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  crne_pkg::fifo_status_t q_stat,
  input  logic [ITEMW-1:0]       q_data,
  output logic                   q_pop,
  output logic                   clearing,
  input  logic [OCW-1:0]         out_count,
  output logic                   out_push,
  output crne_pkg::out_item_t    out_data
);

  crne_pkg::back_state_t st_r, st_nxt;

  crne_pkg::row_t   ctx_mem [NUM_CONTEXTS];
  crne_pkg::row_t   row_q_r;
  logic             mem_re, mem_we;
  logic [CW-1:0]    mem_raddr, mem_waddr;
  crne_pkg::row_t   mem_wdata;

  logic [CW-1:0]    clr_idx_r, clr_idx_nxt;
  logic [ITEMW-1:0] cur_r, cur_nxt;
  logic [7:0]       cur_byte;
  logic [CW-1:0]    cur_ctx_hi, cur_ctx_lo;
  logic [CW-1:0]    q_ctx_hi;

  logic [7:0]       pend_bits_r, pend_bits_nxt;
  logic [2:0]       pend_cnt_r, pend_cnt_nxt;
  logic             hold_v_r, hold_v_nxt;
  logic [7:0]       hold_byte_r, hold_byte_nxt;
  logic             flush_v_r, flush_v_nxt;
  logic [7:0]       flush_byte_r, flush_byte_nxt;

  // nibble step
  logic [3:0]       nib, rank, rank_m1, above, here;
  crne_pkg::row_t   upd_row;
  logic [15:0]      entry;
  logic [3:0]       len;
  logic [8:0]       msk;
  logic [7:0]       bits;
  logic [3:0]       total;
  logic [4:0]       sh;
  logic [15:0]      acc;
  logic             made;
  logic [7:0]       made_byte;
  logic             room_ok;

  assign cur_byte   = cur_r[ITEMW-1 -: 8];
  assign cur_ctx_hi = cur_r[2*CW-1 -: CW];
  assign cur_ctx_lo = cur_r[CW-1:0];
  assign q_ctx_hi   = q_data[2*CW-1 -: CW];
  assign clearing   = (st_r == crne_pkg::ST_CLEAR);

  // a byte gives at most two output beats, so two free slots are needed
  assign room_ok = (32'(out_count) + 32'(flush_v_r) + 2) <= OUT_DEPTH;

  always_comb begin
    nib     = (st_r == crne_pkg::ST_HI_UPD) ? cur_byte[7:4] : cur_byte[3:0];
    rank    = row_q_r.s2r[nib];
    rank_m1 = rank - 4'd1;
    above   = row_q_r.r2s[rank_m1];
    here    = row_q_r.r2s[rank];
    upd_row = row_q_r;
    // transpose: move the symbol one rank up
    if (rank != 4'd0) begin
      upd_row.r2s[rank_m1] = here;
      upd_row.r2s[rank]    = above;
      upd_row.s2r[above]   = rank;
      upd_row.s2r[here]    = rank_m1;
    end
    entry              = crne_pkg::CODE_TAB[row_q_r.code_state][rank];
    upd_row.code_state = entry[13:12];
    len                = entry[11:8];
    msk                = 9'((9'd1 << len) - 9'd1);
    bits               = entry[7:0] & msk[7:0];
    total              = {1'b0, pend_cnt_r} + len;
    sh                 = 5'd16 - {1'b0, total};
    acc                = {pend_bits_r, 8'h00} | ({8'h00, bits} << sh);
    made               = total[3];
    made_byte          = acc[15:8];
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      crne_pkg::ST_CLEAR: begin
        if (clr_idx_r == CW'(NUM_CONTEXTS - 1)) begin
          st_nxt = crne_pkg::ST_IDLE;
        end
      end
      crne_pkg::ST_IDLE: begin
        if (!q_stat.empty && room_ok) begin
          st_nxt = crne_pkg::ST_HI_UPD;
        end
      end
      crne_pkg::ST_HI_UPD: st_nxt = crne_pkg::ST_LO_RD;
      crne_pkg::ST_LO_RD:  st_nxt = crne_pkg::ST_LO_UPD;
      crne_pkg::ST_LO_UPD: st_nxt = crne_pkg::ST_IDLE;
      default:             st_nxt = crne_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mem_re   = 1'b0;
    mem_raddr = q_ctx_hi;
    mem_we   = 1'b0;
    mem_waddr = cur_ctx_hi;
    mem_wdata = upd_row;
    q_pop    = 1'b0;
    out_push = 1'b0;
    out_data = '{out_byte: flush_byte_r, last: 1'b1};
    case (st_r)
      crne_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = crne_pkg::row_reset();
      end
      crne_pkg::ST_IDLE: begin
        out_push = flush_v_r;
        if (!q_stat.empty && room_ok) begin
          mem_re = 1'b1;
          q_pop  = 1'b1;
        end
      end
      crne_pkg::ST_HI_UPD: begin
        mem_we = 1'b1;
      end
      crne_pkg::ST_LO_RD: begin
        mem_re    = 1'b1;
        mem_raddr = cur_ctx_lo;
      end
      crne_pkg::ST_LO_UPD: begin
        mem_we    = 1'b1;
        mem_waddr = cur_ctx_lo;
        if (hold_v_r) begin
          out_push = 1'b1;
          out_data = '{out_byte: hold_byte_r, last: !made};
        end else if (made) begin
          out_push = 1'b1;
          out_data = '{out_byte: made_byte, last: 1'b1};
        end
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_comb begin
    clr_idx_nxt    = clr_idx_r;
    cur_nxt        = cur_r;
    pend_bits_nxt  = pend_bits_r;
    pend_cnt_nxt   = pend_cnt_r;
    hold_v_nxt     = hold_v_r;
    hold_byte_nxt  = hold_byte_r;
    flush_v_nxt    = flush_v_r;
    flush_byte_nxt = flush_byte_r;
    case (st_r)
      crne_pkg::ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
      crne_pkg::ST_IDLE: begin
        flush_v_nxt = 1'b0;
        if (q_pop) begin
          cur_nxt = q_data;
        end
      end
      crne_pkg::ST_HI_UPD, crne_pkg::ST_LO_UPD: begin
        pend_bits_nxt = made ? acc[7:0] : acc[15:8];
        pend_cnt_nxt  = total[2:0];
        if (st_r == crne_pkg::ST_HI_UPD) begin
          hold_v_nxt    = made;
          hold_byte_nxt = made_byte;
        end else begin
          hold_v_nxt     = 1'b0;
          flush_v_nxt    = hold_v_r && made;
          flush_byte_nxt = made_byte;
        end
      end
      default: begin
        clr_idx_nxt = clr_idx_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= crne_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      pend_bits_r <= 8'h00;
      pend_cnt_r  <= 3'd0;
      hold_v_r    <= 1'b0;
      flush_v_r   <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_idx_r   <= clr_idx_nxt;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      hold_v_r    <= hold_v_nxt;
      flush_v_r   <= flush_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    hold_byte_r  <= hold_byte_nxt;
    flush_byte_r <= flush_byte_nxt;
  end

  // context row memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ctx_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      row_q_r <= ctx_mem[mem_raddr];
    end
  end

  `CRNE_ASSERT(a_clear_quiet, st_r == crne_pkg::ST_CLEAR |-> !q_pop && !out_push, "work during clear pass")
  `CRNE_ASSERT(a_out_room, out_push |-> 32'(out_count) < OUT_DEPTH, "output queue has no room")
  `CRNE_ASSERT(a_flush_once, flush_v_r |=> !flush_v_r, "deferred beat not sent")
  `CRNE_ASSERT(a_hold_in_byte, st_r == crne_pkg::ST_IDLE |-> !hold_v_r, "held beat left over")

endmodule

// ===== bench/crne_code_byte_checker.sv =====
// checker for the context rank nibble encoder: predicts the code bytes and compares them
module crne_code_byte_checker #(
  parameter int NUM_CONTEXTS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte_in,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       out_last,
  output int         fail_count,
  output int         bytes_left,
  output int         bytes_seen
);

  // [15:12] next code state, [11:8] code length, [7:0] code bits
  localparam logic [15:0] PREFIX_CODES [4][16] = '{
    '{16'h0100, 16'h0202, 16'h1306, 16'h140E, 16'h2778, 16'h2779, 16'h277A, 16'h277B,
      16'h38F8, 16'h38F9, 16'h38FA, 16'h38FB, 16'h38FC, 16'h38FD, 16'h38FE, 16'h38FF},
    '{16'h0200, 16'h0201, 16'h1304, 16'h1305, 16'h240C, 16'h240D, 16'h251C, 16'h251D,
      16'h363C, 16'h363D, 16'h38F8, 16'h38F9, 16'h38FA, 16'h38FB, 16'h38FC, 16'h38FD},
    '{16'h1300, 16'h1301, 16'h1302, 16'h1303, 16'h2408, 16'h2409, 16'h240A, 16'h240B,
      16'h3518, 16'h3519, 16'h351A, 16'h351B, 16'h351C, 16'h351D, 16'h351E, 16'h351F},
    '{16'h2400, 16'h2401, 16'h2402, 16'h2403, 16'h2404, 16'h2405, 16'h2406, 16'h2407,
      16'h3408, 16'h3409, 16'h340A, 16'h340B, 16'h340C, 16'h340D, 16'h340E, 16'h340F}
  };

  logic [3:0] rank_sym [4096];
  logic [3:0] sym_rank [4096];
  logic [1:0] ctx_state [256];
  logic [7:0] history;
  logic [7:0] held_bits;
  logic [2:0] held_count;

  crne_pkg::out_item_t code_q [$];

  // move-up-one rank update, then prefix code and bit packing
  function automatic logic encode_nibble(input logic [3:0] nib, output logic [7:0] done_byte);
    int unsigned ctx, base, rank, above, here, total, len, bits, acc;
    logic [15:0] entry;
    logic made;
    made = 1'b0;
    done_byte = 8'h00;
    ctx = history % NUM_CONTEXTS;
    base = (ctx & 255) << 4;
    rank = sym_rank[base | nib];
    if (rank > 0) begin
      above = rank_sym[base | (rank - 1)];
      here = rank_sym[base | rank];
      rank_sym[base | (rank - 1)] = here[3:0];
      rank_sym[base | rank] = above[3:0];
      sym_rank[base | above] = rank[3:0];
      sym_rank[base | here] = 4'(rank - 1);
    end
    history = {history[3:0], nib};
    entry = PREFIX_CODES[ctx_state[ctx & 255]][rank];
    len = entry[11:8];
    bits = entry[7:0] & ((1 << len) - 1);
    ctx_state[ctx & 255] = entry[13:12];
    total = held_count + len;
    acc = ((held_bits << 8) | (bits << (16 - total))) & 16'hFFFF;
    if (total >= 8) begin
      done_byte = acc[15:8];
      acc = (acc << 8) & 16'hFFFF;
      total = total - 8;
      made = 1'b1;
    end
    held_bits = acc[15:8];
    held_count = total[2:0];
    return made;
  endfunction

  always @(posedge clk) begin : watch
    crne_pkg::out_item_t want;
    crne_pkg::out_item_t hi_item;
    crne_pkg::out_item_t lo_item;
    logic hi_done;
    logic lo_done;
    if (!rst_n) begin
      for (int i = 0; i < 4096; i++) begin
        rank_sym[i] = 4'(i);
        sym_rank[i] = 4'(i);
      end
      for (int i = 0; i < 256; i++) ctx_state[i] = 2'd3;
      history = 8'h00;
      held_bits = 8'h00;
      held_count = 3'd0;
      code_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        bytes_seen++;
        if (code_q.size() == 0) begin
          $error("unexpected code byte %02h (last %0b)", out_byte, out_last);
          fail_count++;
        end else begin
          want = code_q.pop_front();
          if (out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_byte);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_last);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        hi_done = encode_nibble(in_byte_in[7:4], hi_item.out_byte);
        lo_done = encode_nibble(in_byte_in[3:0], lo_item.out_byte);
        hi_item.last = !lo_done;
        lo_item.last = 1'b1;
        if (hi_done) code_q.push_back(hi_item);
        if (lo_done) code_q.push_back(lo_item);
      end
    end
    bytes_left <= code_q.size();
  end

endmodule

// ===== bench/context_rank_nibble_encoder_core_test.sv =====
// top of the encoder bench: stimulus, handshake idling, run limit and verdict
module context_rank_nibble_encoder_core_test;

  localparam int RUN_LIMIT  = 400000;  // cycles, far above the slowest legal run
  localparam int PHASE_LEN  = 550;     // random beats per idling mix
  localparam int TAIL_WAIT  = 40;      // cycles after the last code byte

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte_in = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  int fail_count;
  int bytes_left;
  int bytes_seen;
  int cycle_count = 0;
  int beats_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  context_rank_nibble_encoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte_in(in_byte_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  // watches both channels, keeps its own model state and counts mismatches
  crne_code_byte_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte_in(in_byte_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .fail_count(fail_count),
    .bytes_left(bytes_left),
    .bytes_seen(bytes_seen)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // receiver back-pressure, rate set per phase
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // hard stop if the block hangs
  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("timeout after %0d cycles, %0d code bytes still owed", cycle_count, bytes_left);
    $display("== FAIL ==");
    $finish;
  end

  // one input beat: random idle cycles first, then hold valid until the block takes it
  task automatic send_beat(input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_in <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // sender goes quiet until every predicted code byte has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_left != 0) @(posedge clk);
  endtask

  // mostly skewed sources so contexts settle and code states walk down,
  // with repeats for the top rank case and some uniform noise
  task automatic random_phase(input int count);
    logic [7:0] alphabet [4];
    logic [7:0] prev;
    logic [7:0] data;
    int pick;
    prev = 8'h00;
    foreach (alphabet[k]) alphabet[k] = 8'($urandom);
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 63) begin
        // new skewed source now and then
        foreach (alphabet[k]) alphabet[k] = 8'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 45) data = alphabet[$urandom_range(pick < 30 ? 1 : 3)];
      else if (pick < 65) data = prev;
      else if (pick < 75) data = {prev[7:4], 4'($urandom)};
      else data = 8'($urandom);
      send_beat(data);
      prev = data;
    end
  endtask

  initial begin
    logic [7:0] directed [$];
    // repeated zeros keep hitting the top rank and drive context 0 down to
    // code state 0; all-ones and mixed nibbles reach the deep ranks of fresh contexts
    directed = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'hF0,
                 8'h5A, 8'hA5, 8'h80, 8'h01, 8'h7E, 8'h81, 8'h3C, 8'hC3, 8'h11,
                 8'hEE, 8'h22, 8'hDD, 8'h96, 8'h69, 8'hFF, 8'h00};

    // synchronous reset, low from time zero; the clear pass shows up as in_stall
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // phase 1: sender rarely idles, receiver stalls a lot
    send_idle_pct = 11;
    recv_stall_pct = 70;
    foreach (directed[k]) send_beat(directed[k]);
    random_phase(PHASE_LEN);
    drain_results();

    // phase 2: roles swapped
    send_idle_pct = 70;
    recv_stall_pct = 11;
    random_phase(PHASE_LEN);
    drain_results();

    // phase 3: full rate on both sides
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(PHASE_LEN);
    in_valid <= 1'b0;

    // wait out the last code bytes, then give stray beats time to show up
    @(posedge clk);
    while (bytes_left != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("encoded %0d input bytes into %0d checked code bytes", beats_sent, bytes_seen);
    $display("idle mixes: sender-light/receiver-heavy, swapped, and no idling");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/crne_pkg.sv
src/crne_fifo.sv
src/crne_front.sv
src/crne_back.sv
src/context_rank_nibble_encoder_core.sv
bench/crne_code_byte_checker.sv
bench/context_rank_nibble_encoder_core_test.sv
